FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the reader's modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: design/rsmr_pkg.sv
// ----------------------------------------------------------------------------
// rsmr_pkg
// Widths and the job descriptor shared by the reverse spiral reader modules.
// ----------------------------------------------------------------------------
package rsmr_pkg;

  localparam int DATA_W     = 32;
  localparam int DIM_W      = 6;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 13;

  // Register indexes on the write channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } cfg_reg_t;

  // One loaded matrix waiting to be read out.
  typedef struct packed {
    logic             bank;
    logic [DIM_W-1:0] rows_m1;
    logic [DIM_W-1:0] cols_m1;
  } job_t;

endpackage

FILE: design/rsmr_elem_if.sv
// ----------------------------------------------------------------------------
// rsmr_elem_if
// Element channel: one matrix element per beat, row-major order.
// ----------------------------------------------------------------------------
interface rsmr_elem_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsmr_pkg::DATA_W-1:0]  element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

FILE: design/rsmr_result_if.sv
// ----------------------------------------------------------------------------
// rsmr_result_if
// Result channel: one element in reverse spiral order per beat.
// ----------------------------------------------------------------------------
interface rsmr_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsmr_pkg::DATA_W-1:0]  out_value;
  logic                                is_last;

  modport source (output valid, output out_value, output is_last, input ready);
  modport sink (input valid, input out_value, input is_last, output ready);
endinterface

FILE: design/rsmr_cfg_if.sv
// ----------------------------------------------------------------------------
// rsmr_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface rsmr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rsmr_pkg::CFG_IDX_W-1:0]     index;
  logic [rsmr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/reverse_spiral_matrix_reader_unit.sv
// ----------------------------------------------------------------------------
// reverse_spiral_matrix_reader_unit
// Loads a matrix in row-major order and returns it in reverse spiral order.
// ----------------------------------------------------------------------------
// Elements are accepted one per cycle, unless both banks await readout, into
// one of two store banks; the rows and columns registers are sampled on the
// first element of each matrix. When a matrix is complete its job passes
// through a two-entry queue to the readout side, which walks the spiral into
// an order list and then reads that list backwards through the order and
// element memories, each element passing the S_RD_ORDER, S_RD_ELEM and S_LOAD
// states, with an output stall holding S_LOAD. Loading of the next matrix runs
// alongside readout; a third matrix waits until the oldest has been read out.
// The final element of each traversal is marked with is_last.
module reverse_spiral_matrix_reader_unit #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic            clk,
  input  logic            rst,
  rsmr_elem_if.sink       element,
  rsmr_cfg_if.sink        cfg,
  rsmr_result_if.source   result
);

  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                        job_push;
  rsmr_pkg::job_t              push_job;
  logic                        job_pop;
  logic                        head_valid;
  rsmr_pkg::job_t              head_job;
  logic                        job_done;
  logic                        mem_we;
  logic [ADDR_W:0]             mem_addr;
  logic [rsmr_pkg::DATA_W-1:0] mem_data;

  rsmr_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .element  (element),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (push_job),
    .job_done (job_done),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_data (mem_data)
  );

  rsmr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  rsmr_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .job_done  (job_done),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .result    (result)
  );

endmodule

FILE: design/rsmr_front.sv
// ----------------------------------------------------------------------------
// rsmr_front
// Holds the dimension registers, loads elements into the store and hands a
// job to the queue when a matrix is complete.
// ----------------------------------------------------------------------------
module rsmr_front #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS,
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  rsmr_elem_if.sink                               element,
  rsmr_cfg_if.sink                                cfg,
  output logic                                    job_push,
  output rsmr_pkg::job_t                          job,
  input  logic                                    job_done,
  output logic                                    mem_we,
  output logic [ADDR_W:0]                         mem_addr,
  output logic [rsmr_pkg::DATA_W-1:0]             mem_data
);

  localparam int DW          = rsmr_pkg::DIM_W;
  localparam int PW          = rsmr_pkg::PROD_W;

  localparam logic [rsmr_pkg::CFG_W-1:0]     DIM_RESET     = 4'd8;

  // Dimension minus one, with zero read as one and oversize saturated.
  function automatic logic [DW-1:0] dim_m1(input logic [rsmr_pkg::CFG_W-1:0] v,
                                           input logic [6:0] maxv);
    logic [6:0] vx;
    vx = 7'(v);
    if (vx == 7'd0) return '0;
    else if (vx > maxv) return DW'(maxv - 7'd1);
    else return DW'(vx - 7'd1);
  endfunction

  logic [rsmr_pkg::CFG_W-1:0] row_count;
  logic [rsmr_pkg::CFG_W-1:0] col_count;
  logic [ADDR_W-1:0]          load_count;
  logic [DW-1:0]              rows_m1;
  logic [DW-1:0]              cols_m1;
  logic                       bank;
  logic [1:0]                 pending;

  logic                       accept;
  logic                       first;
  logic [DW-1:0]              rows_m1_cur;
  logic [DW-1:0]              cols_m1_cur;
  logic [PW-1:0]              total;
  logic                       complete;

  assign cfg.ready = 1'b1;

  // Two store banks: a new matrix may load while at most one other is read.
  assign element.ready = (pending != 2'd2);
  assign accept        = element.valid && element.ready;

  assign first       = (load_count == '0);
  assign rows_m1_cur = first ? dim_m1(row_count, 7'(MAX_ROWS)) : rows_m1;
  assign cols_m1_cur = first ? dim_m1(col_count, 7'(MAX_COLS)) : cols_m1;
  assign total       = PW'({1'b0, rows_m1_cur} + 7'd1) * PW'({1'b0, cols_m1_cur} + 7'd1);
  assign complete    = (PW'(load_count) == total - PW'(1));

  assign mem_we   = accept;
  assign mem_addr = {bank, load_count};
  assign mem_data = element.element_value;

  assign job_push     = accept && complete;
  assign job.bank     = bank;
  assign job.rows_m1  = rows_m1_cur;
  assign job.cols_m1  = cols_m1_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rsmr_pkg::REG_ROW_COUNT: row_count <= cfg.data[rsmr_pkg::CFG_W-1:0];
        rsmr_pkg::REG_COL_COUNT: col_count <= cfg.data[rsmr_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      bank       <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        load_count <= '0;
        bank       <= ~bank;
      end else begin
        load_count <= load_count + ADDR_W'(1);
      end
    end
  end

  // Dimensions are latched on the first element of each matrix.
  always_ff @(posedge clk) begin
    if (accept && first) begin
      rows_m1 <= rows_m1_cur;
      cols_m1 <= cols_m1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      case ({job_push, job_done})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

endmodule

FILE: design/rsmr_queue.sv
// ----------------------------------------------------------------------------
// rsmr_queue
// Two-entry job queue between the loading side and the readout side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsmr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsmr_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output rsmr_pkg::job_t head_job
);

  rsmr_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push && !pop, count != 2'd2)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, count != 2'd0)
  `ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3)

endmodule

FILE: design/rsmr_back.sv
// ----------------------------------------------------------------------------
// rsmr_back
// Walks the spiral of a queued matrix into an order list, then reads the
// list backwards and delivers the stored elements through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsmr_back #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS,
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  rsmr_pkg::job_t               job,
  output logic                         job_pop,
  output logic                         job_done,
  input  logic                         mem_we,
  input  logic [ADDR_W:0]              mem_addr,
  input  logic [rsmr_pkg::DATA_W-1:0]  mem_data,
  rsmr_result_if.source                result
);

  localparam int DW          = rsmr_pkg::DIM_W;
  localparam int PW          = rsmr_pkg::PROD_W;
  localparam int SW          = ADDR_W + 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEN,
    S_RD_ORDER,
    S_RD_ELEM,
    S_LOAD
  } state_t;

  typedef enum logic [1:0] {
    D_RIGHT,
    D_DOWN,
    D_LEFT,
    D_UP
  } dir_t;

  logic [rsmr_pkg::DATA_W-1:0] elem_mem  [2**(ADDR_W+1)];
  logic [ADDR_W-1:0]           order_mem [STORE_DEPTH];

  state_t                      state;
  logic                        bank;
  logic [ADDR_W-1:0]           k;
  logic [ADDR_W-1:0]           k_last;
  logic [ADDR_W-1:0]           col_step;
  logic [ADDR_W-1:0]           order_q;
  logic [rsmr_pkg::DATA_W-1:0] elem_q;
  logic                        out_valid;
  logic signed [rsmr_pkg::DATA_W-1:0] out_value;
  logic                        is_last;

  dir_t                        walk_dir;
  logic [DW-1:0]               walk_r;
  logic [DW-1:0]               walk_c;
  logic [DW-1:0]               walk_top;
  logic [DW-1:0]               walk_bottom;
  logic [DW-1:0]               walk_lft;
  logic [DW-1:0]               walk_rgt;
  logic [ADDR_W-1:0]           walk_addr;

  dir_t                        walk_dir_next;
  logic [DW-1:0]               walk_r_next;
  logic [DW-1:0]               walk_c_next;
  logic [DW-1:0]               walk_top_next;
  logic [DW-1:0]               walk_bottom_next;
  logic [DW-1:0]               walk_lft_next;
  logic [DW-1:0]               walk_rgt_next;
  logic [ADDR_W-1:0]           walk_addr_next;

  logic [PW-1:0]               job_total;
  logic [SW-1:0]               job_cols;

  assign job_pop   = (state == S_IDLE) && job_valid;
  assign job_total = PW'({1'b0, job.rows_m1} + 7'd1) * PW'({1'b0, job.cols_m1} + 7'd1);
  assign job_cols  = SW'(job.cols_m1) + SW'(1);

  assign result.valid     = out_valid;
  assign result.out_value = out_value;
  assign result.is_last   = is_last;

  // One step of the clockwise spiral: move along the current edge, or turn
  // and pull in the bound of the edge just finished.
  always_comb begin
    walk_dir_next    = walk_dir;
    walk_r_next      = walk_r;
    walk_c_next      = walk_c;
    walk_top_next    = walk_top;
    walk_bottom_next = walk_bottom;
    walk_lft_next    = walk_lft;
    walk_rgt_next    = walk_rgt;
    walk_addr_next   = walk_addr;
    case (walk_dir)
      D_RIGHT: begin
        if (walk_c == walk_rgt) begin
          walk_dir_next  = D_DOWN;
          walk_top_next  = walk_top + DW'(1);
          walk_r_next    = walk_r + DW'(1);
          walk_addr_next = walk_addr + col_step;
        end else begin
          walk_c_next    = walk_c + DW'(1);
          walk_addr_next = walk_addr + ADDR_W'(1);
        end
      end
      D_DOWN: begin
        if (walk_r == walk_bottom) begin
          walk_dir_next  = D_LEFT;
          walk_rgt_next  = walk_rgt - DW'(1);
          walk_c_next    = walk_c - DW'(1);
          walk_addr_next = walk_addr - ADDR_W'(1);
        end else begin
          walk_r_next    = walk_r + DW'(1);
          walk_addr_next = walk_addr + col_step;
        end
      end
      D_LEFT: begin
        if (walk_c == walk_lft) begin
          walk_dir_next    = D_UP;
          walk_bottom_next = walk_bottom - DW'(1);
          walk_r_next      = walk_r - DW'(1);
          walk_addr_next   = walk_addr - col_step;
        end else begin
          walk_c_next    = walk_c - DW'(1);
          walk_addr_next = walk_addr - ADDR_W'(1);
        end
      end
      D_UP: begin
        if (walk_r == walk_top) begin
          walk_dir_next  = D_RIGHT;
          walk_lft_next  = walk_lft + DW'(1);
          walk_c_next    = walk_c + DW'(1);
          walk_addr_next = walk_addr + ADDR_W'(1);
        end else begin
          walk_r_next    = walk_r - DW'(1);
          walk_addr_next = walk_addr - col_step;
        end
      end
      default: ;
    endcase
  end

  // Element store, double banked; the loading side writes the other bank.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[mem_addr] <= mem_data;
    end
    elem_q <= elem_mem[{bank, order_q}];
  end

  always_ff @(posedge clk) begin
    if (state == S_GEN) begin
      order_mem[k] <= walk_addr;
    end
    order_q <= order_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      job_done  <= 1'b0;
    end else begin
      // The last beat of a traversal enters the output register this cycle.
      job_done <= (state == S_LOAD) && (!out_valid || result.ready) && (k == '0);
      if (result.ready && state != S_LOAD) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            bank        <= job.bank;
            k           <= '0;
            k_last      <= ADDR_W'(job_total - PW'(1));
            col_step    <= job_cols[ADDR_W-1:0];
            walk_dir    <= D_RIGHT;
            walk_r      <= '0;
            walk_c      <= '0;
            walk_top    <= '0;
            walk_bottom <= job.rows_m1;
            walk_lft    <= '0;
            walk_rgt    <= job.cols_m1;
            walk_addr   <= '0;
            state       <= S_GEN;
          end
        end
        S_GEN: begin
          walk_dir    <= walk_dir_next;
          walk_r      <= walk_r_next;
          walk_c      <= walk_c_next;
          walk_top    <= walk_top_next;
          walk_bottom <= walk_bottom_next;
          walk_lft    <= walk_lft_next;
          walk_rgt    <= walk_rgt_next;
          walk_addr   <= walk_addr_next;
          if (k == k_last) begin
            state <= S_RD_ORDER;
          end else begin
            k <= k + ADDR_W'(1);
          end
        end
        S_RD_ORDER: state <= S_RD_ELEM;
        S_RD_ELEM:  state <= S_LOAD;
        S_LOAD: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_value <= elem_q;
            is_last   <= (k == '0);
            if (k == '0) begin
              state    <= S_IDLE;
            end else begin
              k     <= k - ADDR_W'(1);
              state <= S_RD_ORDER;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_done_with_last, clk, rst, job_done, out_valid && is_last)
  `ASSERT_IMPLIES(a_gen_in_range, clk, rst, state == S_GEN, k <= k_last)
  `ASSERT_IMPLIES(a_walk_in_store, clk, rst, state == S_GEN, (ADDR_W+1)'(walk_addr) < (ADDR_W+1)'(STORE_DEPTH))

endmodule
